[rtl/abre_pkg.sv]
// ----------------------------------------------------------------------------
// Adaptive binary range encoder package
// Shared types, codes and constants of the range encoder block.
// ----------------------------------------------------------------------------
package abre_pkg;

  // Probability store geometry.
  localparam int unsigned CONTEXTS  = 256;
  localparam int unsigned CTX_BITS  = 8;
  localparam int unsigned PROB_BITS = 11;

  // Coder register widths.
  localparam int unsigned LOW_BITS     = 33;
  localparam int unsigned RANGE_BITS   = 32;
  localparam int unsigned PENDING_BITS = 32;
  localparam int unsigned RUN_LEN_BITS = 32;
  localparam int unsigned SHIFT_BITS   = 4;
  localparam int unsigned PASS_BITS    = 3;

  localparam logic [PROB_BITS-1:0] PROB_MAX = {PROB_BITS{1'b1}};
  localparam logic [PROB_BITS:0]   PROB_TOTAL = {1'b1, {PROB_BITS{1'b0}}};
  localparam logic [PENDING_BITS-1:0] PENDING_MAX = {PENDING_BITS{1'b1}};
  localparam logic [RANGE_BITS-1:0] RANGE_INIT = {RANGE_BITS{1'b1}};

  // A flush shifts out five bytes; the counter runs from zero to FLUSH_LAST.
  localparam int unsigned FLUSH_CNT_BITS = 3;
  localparam logic [FLUSH_CNT_BITS-1:0] FLUSH_LAST = 3'd4;

  // Output queue geometry.
  localparam int unsigned OUT_DEPTH    = 2;
  localparam int unsigned OUT_PTR_BITS = 1;

  // Reset values of the configuration registers.
  localparam logic [SHIFT_BITS-1:0] FAST_SHIFT_RST = 4'd4;
  localparam logic [SHIFT_BITS-1:0] SLOW_SHIFT_RST = 4'd5;
  localparam logic [PASS_BITS-1:0]  FAST_PASS_RST  = 3'd2;

  // Command codes.
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FAST_SHIFT = 2'd0,
    CFG_SLOW_SHIFT = 2'd1,
    CFG_FAST_PASS  = 2'd2
  } cfg_idx_e;

  // Coder sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_SH2,
    ST_FLUSH
  } coder_state_e;

  typedef struct packed {
    logic                 command;
    logic                 bit_value;
    logic [CTX_BITS-1:0]  context_req;
    logic [PASS_BITS-1:0] pass_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0]              head_byte;
    logic [7:0]              run_byte;
    logic [RUN_LEN_BITS-1:0] run_length;
    logic                    run_overflow;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic [SHIFT_BITS-1:0] fast_shift;
    logic [SHIFT_BITS-1:0] slow_shift;
    logic [PASS_BITS-1:0]  fast_pass;
  } cfg_t;

  // Control of the probability store by the coder.
  typedef struct packed {
    logic                 rd_en;
    logic [CTX_BITS-1:0]  rd_addr;
    logic                 wr_en;
    logic [CTX_BITS-1:0]  wr_addr;
    logic [PROB_BITS-1:0] wr_data;
    logic                 clear;
  } store_ctl_t;

endpackage

[rtl/abre_prob_store.sv]
// ----------------------------------------------------------------------------
// Probability store
// Synchronous single-port-read, single-port-write probability memory with
// one valid bit per entry; an entry that is not valid reads as PROB_MAX.
// ----------------------------------------------------------------------------
module abre_prob_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  abre_pkg::store_ctl_t             ctl_i,
  output logic [abre_pkg::PROB_BITS-1:0]   prob_o
);

  logic [abre_pkg::PROB_BITS-1:0] mem_q [abre_pkg::CONTEXTS];
  logic [abre_pkg::CONTEXTS-1:0]  valid_q;
  logic [abre_pkg::PROB_BITS-1:0] rd_data_q;
  logic                           rd_valid_q;

  // Memory array and registered read data.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[ctl_i.wr_addr] <= ctl_i.wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[ctl_i.rd_addr];
    end
  end

  // Valid bits: cleared at once by reset or by a flush, set on a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        valid_q <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[ctl_i.wr_addr] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[ctl_i.rd_addr] && !ctl_i.clear;
      end
    end
  end

  assign prob_o = rd_valid_q ? rd_data_q : abre_pkg::PROB_MAX;

endmodule

[rtl/abre_out_fifo.sv]
// ----------------------------------------------------------------------------
// Result queue
// Two-entry queue between the coder and the output channel, so that the
// coder keeps working while a finished result waits for its transfer.
// ----------------------------------------------------------------------------
module abre_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  abre_pkg::out_item_t  push_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output abre_pkg::out_item_t  out_data_o
);

  abre_pkg::out_item_t                 entry_q [abre_pkg::OUT_DEPTH];
  logic [abre_pkg::OUT_PTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [abre_pkg::OUT_PTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [abre_pkg::OUT_PTR_BITS:0]     count_q, count_d;
  logic                                pop;

  assign full_o      = (count_q == (abre_pkg::OUT_PTR_BITS+1)'(abre_pkg::OUT_DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = entry_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/abre_coder.sv]
// ----------------------------------------------------------------------------
// Range coder sequencer
// Reads the context probability, multiplies, adapts and writes it back, updates
// low and range, and shifts one byte group per cycle unless the queue is full.
// ----------------------------------------------------------------------------
module abre_coder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  abre_pkg::cfg_t                 cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  abre_pkg::in_item_t             in_data_i,
  input  logic [abre_pkg::PROB_BITS-1:0] prob_i,
  output abre_pkg::store_ctl_t           store_ctl_o,
  output logic                           push_o,
  output abre_pkg::out_item_t            push_data_o,
  input  logic                           full_i
);

  localparam int unsigned LB  = abre_pkg::LOW_BITS;
  localparam int unsigned RB  = abre_pkg::RANGE_BITS;
  localparam int unsigned PB  = abre_pkg::PROB_BITS;
  localparam int unsigned PDB = abre_pkg::PENDING_BITS;

  abre_pkg::coder_state_e state_q, state_d;

  logic [LB-1:0]                        low_q, low_d;
  logic [RB-1:0]                        range_q, range_d;
  logic [7:0]                           cache_q, cache_d;
  logic [PDB-1:0]                       pend_q, pend_d;
  logic                                 lost_q, lost_d;
  logic [abre_pkg::FLUSH_CNT_BITS-1:0]  flush_cnt_q, flush_cnt_d;
  logic [RB-1:0]                        bound_q, bound_d;
  logic                                 bit_q, bit_d;
  logic [abre_pkg::CTX_BITS-1:0]        ctx_q, ctx_d;
  logic [abre_pkg::PASS_BITS-1:0]       pass_q, pass_d;

  logic                                 accept;
  logic [abre_pkg::SHIFT_BITS-1:0]      adapt_sh;
  logic [RB-PB-1:0]                     range_hi;
  logic [RB-1:0]                        bound_calc;
  logic [PB:0]                          p_gap;
  logic [PB:0]                          p_up;
  logic [PB-1:0]                        p_dn;
  logic [PB-1:0]                        p_new;

  logic [LB-1:0]                        low_n;
  logic [RB-1:0]                        range_n;
  logic                                 renorm1;
  logic                                 need2;

  logic                                 shift_act;
  logic [LB-1:0]                        sh_low;
  logic                                 sh_emit;
  logic                                 sh_carry;
  logic                                 flush_end;
  logic                                 go;

  assign accept = in_valid_i && in_ready_o;

  // Multiply stage: split point of the range and the adapted probability.
  assign adapt_sh   = (pass_q == cfg_i.fast_pass) ? cfg_i.fast_shift : cfg_i.slow_shift;
  assign range_hi   = range_q[RB-1:PB];
  assign bound_calc = RB'(range_hi) * RB'(prob_i);
  assign p_gap      = abre_pkg::PROB_TOTAL - {1'b0, prob_i};
  assign p_up       = {1'b0, prob_i} + (p_gap >> adapt_sh);
  assign p_dn       = prob_i - (prob_i >> adapt_sh);

  always_comb begin
    if (!bit_q) begin
      p_new = (p_up > {1'b0, abre_pkg::PROB_MAX}) ? abre_pkg::PROB_MAX : p_up[PB-1:0];
    end else begin
      p_new = (p_dn == '0) ? PB'(1) : p_dn;
    end
  end

  // Update stage: new low and range, and whether one or two shifts follow.
  always_comb begin
    if (bit_q) begin
      low_n   = low_q + LB'(bound_q);
      range_n = range_q - bound_q;
    end else begin
      low_n   = low_q;
      range_n = bound_q;
    end
  end

  assign renorm1 = (range_n[RB-1:RB-8] == '0);
  assign need2   = (range_n[RB-1:RB-16] == '0);

  // Byte shifter, shared by renormalization and flush.
  assign shift_act = ((state_q == abre_pkg::ST_UPD) && renorm1) ||
                     (state_q == abre_pkg::ST_SH2) || (state_q == abre_pkg::ST_FLUSH);
  assign sh_low    = (state_q == abre_pkg::ST_UPD) ? low_n : low_q;
  assign sh_carry  = sh_low[LB-1];
  assign sh_emit   = sh_carry || (sh_low[LB-2:LB-9] != 8'hFF);
  assign flush_end = (state_q == abre_pkg::ST_FLUSH) && (flush_cnt_q == abre_pkg::FLUSH_LAST);

  // A step that emits waits while the result queue is full.
  assign go     = !(shift_act && sh_emit) || !full_i;
  assign push_o = shift_act && sh_emit && !full_i;

  always_comb begin
    push_data_o.head_byte    = cache_q + {7'b0, sh_carry};
    push_data_o.run_byte     = 8'hFF + {7'b0, sh_carry};
    push_data_o.run_length   = abre_pkg::RUN_LEN_BITS'(pend_q - PDB'(1));
    push_data_o.run_overflow = lost_q;
    push_data_o.last         = flush_end;
  end

  // Input handshake: a new item may enter once the range is settled.
  always_comb begin
    unique case (state_q)
      abre_pkg::ST_IDLE: in_ready_o = 1'b1;
      abre_pkg::ST_UPD:  in_ready_o = go && !(renorm1 && need2);
      abre_pkg::ST_SH2:  in_ready_o = go;
      default:           in_ready_o = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      abre_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.command == abre_pkg::CMD_FLUSH) ?
                    abre_pkg::ST_FLUSH : abre_pkg::ST_MUL;
        end
      end
      abre_pkg::ST_MUL: begin
        state_d = abre_pkg::ST_UPD;
      end
      abre_pkg::ST_UPD, abre_pkg::ST_SH2: begin
        if (go) begin
          if ((state_q == abre_pkg::ST_UPD) && renorm1 && need2) begin
            state_d = abre_pkg::ST_SH2;
          end else if (accept) begin
            state_d = (in_data_i.command == abre_pkg::CMD_FLUSH) ?
                      abre_pkg::ST_FLUSH : abre_pkg::ST_MUL;
          end else begin
            state_d = abre_pkg::ST_IDLE;
          end
        end
      end
      abre_pkg::ST_FLUSH: begin
        if (go && flush_end) begin
          state_d = abre_pkg::ST_IDLE;
        end
      end
      default: state_d = abre_pkg::ST_IDLE;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    low_d       = low_q;
    range_d     = range_q;
    cache_d     = cache_q;
    pend_d      = pend_q;
    lost_d      = lost_q;
    flush_cnt_d = flush_cnt_q;
    bound_d     = bound_q;
    bit_d       = bit_q;
    ctx_d       = ctx_q;
    pass_d      = pass_q;

    if (accept) begin
      bit_d       = in_data_i.bit_value;
      ctx_d       = in_data_i.context_req;
      pass_d      = in_data_i.pass_code;
      flush_cnt_d = '0;
    end

    if (state_q == abre_pkg::ST_MUL) begin
      bound_d = bound_calc;
    end

    if ((state_q == abre_pkg::ST_UPD) && go) begin
      low_d   = low_n;
      range_d = range_n;
      if (renorm1) begin
        range_d = range_n << 8;
      end
    end

    if ((state_q == abre_pkg::ST_SH2) && go) begin
      range_d = range_q << 8;
    end

    if ((state_q == abre_pkg::ST_FLUSH) && go) begin
      flush_cnt_d = flush_cnt_q + 1'b1;
    end

    // Shift one byte of low out, settling or extending the pending run.
    if (shift_act && go) begin
      low_d = {1'b0, sh_low[LB-10:0], 8'h00};
      if (sh_emit) begin
        lost_d  = 1'b0;
        cache_d = sh_low[LB-2:LB-9];
        pend_d  = PDB'(1);
      end else if (pend_q == abre_pkg::PENDING_MAX) begin
        lost_d = 1'b1;
      end else begin
        pend_d = pend_q + PDB'(1);
      end
    end

    // The last flush shift returns the coder to its initial state.
    if (flush_end && go) begin
      low_d   = '0;
      range_d = abre_pkg::RANGE_INIT;
      cache_d = '0;
      pend_d  = PDB'(1);
      lost_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abre_pkg::ST_IDLE;
      low_q       <= '0;
      range_q     <= abre_pkg::RANGE_INIT;
      cache_q     <= '0;
      pend_q      <= PDB'(1);
      lost_q      <= 1'b0;
      flush_cnt_q <= '0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      range_q     <= range_d;
      cache_q     <= cache_d;
      pend_q      <= pend_d;
      lost_q      <= lost_d;
      flush_cnt_q <= flush_cnt_d;
    end
  end

  // Item fields and the registered product.
  always_ff @(posedge clk_i) begin
    bound_q <= bound_d;
    bit_q   <= bit_d;
    ctx_q   <= ctx_d;
    pass_q  <= pass_d;
  end

  // Probability store access: read on transfer, write back in the multiply step.
  always_comb begin
    store_ctl_o.rd_en   = accept;
    store_ctl_o.rd_addr = in_data_i.context_req;
    store_ctl_o.wr_en   = (state_q == abre_pkg::ST_MUL);
    store_ctl_o.wr_addr = ctx_q;
    store_ctl_o.wr_data = p_new;
    store_ctl_o.clear   = flush_end && go;
  end

endmodule

[rtl/adaptive_binary_range_encoder_unit.sv]
// ----------------------------------------------------------------------------
// Adaptive binary range encoder
// Flow: an encode bit reads its probability on transfer, then passes the
// multiply and update states, and a shift state if it needs two
// renormalization shifts; a flush shifts out five bytes in the flush state.
// The next item may enter in an encode bit's last update or shift state.
// Reset: coder state returns to its initial values and the probability valid
// bits clear at once, so no clearing pass follows reset or a flush.
// ----------------------------------------------------------------------------
module adaptive_binary_range_encoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  abre_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output abre_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [3:0]          cfg_data_i
);

  abre_pkg::cfg_t                   cfg_q;
  abre_pkg::store_ctl_t             store_ctl;
  logic [abre_pkg::PROB_BITS-1:0]   prob;
  logic                             push;
  abre_pkg::out_item_t              push_data;
  logic                             full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_shift <= abre_pkg::FAST_SHIFT_RST;
      cfg_q.slow_shift <= abre_pkg::SLOW_SHIFT_RST;
      cfg_q.fast_pass  <= abre_pkg::FAST_PASS_RST;
    end else if (cfg_we_i) begin
      unique case (abre_pkg::cfg_idx_e'(cfg_idx_i))
        abre_pkg::CFG_FAST_SHIFT: cfg_q.fast_shift <= cfg_data_i;
        abre_pkg::CFG_SLOW_SHIFT: cfg_q.slow_shift <= cfg_data_i;
        abre_pkg::CFG_FAST_PASS:  cfg_q.fast_pass  <= cfg_data_i[abre_pkg::PASS_BITS-1:0];
        default: ;
      endcase
    end
  end

  abre_prob_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (store_ctl),
    .prob_o (prob)
  );

  abre_coder u_coder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .prob_i      (prob),
    .store_ctl_o (store_ctl),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  abre_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // A result is never pushed into a full queue.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("result pushed into full queue");

  // The cycle after a transfer the coder is busy with that item.
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken in the cycle after a transfer");

  // An encode transfer writes its adapted probability back in the following cycle.
  a_writeback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.command == abre_pkg::CMD_ENCODE))
    |=> store_ctl.wr_en)
    else $error("probability write-back missing");

  // The store is never written or read in a cycle in which it is cleared.
  a_no_write_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_ctl.clear |-> !store_ctl.wr_en && !store_ctl.rd_en)
    else $error("store cleared while accessed");
`endif

endmodule
